// File: rtl/rtp_pkg.sv
package rtp_pkg;

   // Angle accumulator: one full turn is 2^ACC_WIDTH
   localparam int ACC_WIDTH  = 32;
   // Fraction bits added below the coordinates inside the rotator
   localparam int GUARD_BITS = 24;
   // Entries in the arctangent table, and so the most rotation steps
   localparam int ATAN_DEPTH = 32;

   localparam logic [ACC_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

   // round(atan(2^-i) / (2*pi) * 2^32)
   localparam logic [ACC_WIDTH-1:0] ATAN_TABLE [0:ATAN_DEPTH-1] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
      32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
      32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
   };

endpackage

// File: rtl/rectangular_to_polar_unit.sv
// Pipeline: capture, squaring, set-up, the iteration steps and the output register.
// Throughput: one point per cycle while no result is held by rsp_stall.
// A stall on the result side freezes the whole pipeline, which then stalls the request side.
// Reset (synchronous, active high) clears only the valid bits; data registers are not reset.
module rectangular_to_polar_unit #(
   parameter int DATA_WIDTH  = 16,
   parameter int ANGLE_WIDTH = 16,
   parameter int STAGES      = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [DATA_WIDTH-1:0]  req_x_coord,
   input  logic signed [DATA_WIDTH-1:0]  req_y_coord,
   input  logic                          req_last_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic        [DATA_WIDTH-1:0]  rsp_magnitude,
   output logic        [ANGLE_WIDTH-1:0] rsp_angle,
   output logic                          rsp_last_out
);

   import rtp_pkg::*;

   // Depth of the iteration section: rotation steps and root digits run side by side
   localparam int D  = (STAGES > DATA_WIDTH) ? STAGES : DATA_WIDTH;
   // Rotator width: coordinate, guard bits, one bit for the half-turn negation and
   // two for the CORDIC growth (about 1.65 * sqrt(2))
   localparam int CW = DATA_WIDTH + GUARD_BITS + 3;
   // Radicand and partial remainder widths of the square root
   localparam int SW = 2 * DATA_WIDTH;
   localparam int RW = DATA_WIDTH + 3;

   // The whole pipeline moves as one; it halts only while a result waits to be taken
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // ------------------------------------------------------------------------
   // Stage 1: capture the point and its absolute values
   // ------------------------------------------------------------------------
   logic                          v1_ff;
   logic                          last1_ff;
   logic signed [DATA_WIDTH-1:0]  x1_ff, y1_ff;
   logic        [DATA_WIDTH-1:0]  ax1_ff, ay1_ff;
   logic        [DATA_WIDTH-1:0]  ax1_in, ay1_in;

   // The most negative value maps to 2^(DATA_WIDTH-1), which still fits unsigned
   assign ax1_in = req_x_coord[DATA_WIDTH-1] ? (~$unsigned(req_x_coord) + 1'b1)
                                             : $unsigned(req_x_coord);
   assign ay1_in = req_y_coord[DATA_WIDTH-1] ? (~$unsigned(req_y_coord) + 1'b1)
                                             : $unsigned(req_y_coord);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
      if (adv) begin
         last1_ff <= req_last_in;
         x1_ff    <= req_x_coord;
         y1_ff    <= req_y_coord;
         ax1_ff   <= ax1_in;
         ay1_ff   <= ay1_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: square both coordinates, one multiplier each
   // ------------------------------------------------------------------------
   logic                          v2_ff;
   logic                          last2_ff;
   logic signed [DATA_WIDTH-1:0]  x2_ff, y2_ff;
   logic        [SW-1:0]          sqx2_ff, sqy2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         last2_ff <= last1_ff;
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         sqx2_ff  <= SW'(ax1_ff) * SW'(ax1_ff);
         sqy2_ff  <= SW'(ay1_ff) * SW'(ay1_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3 (index 0 of the iteration arrays): form the radicand and set up
   // the rotator; a point in the left half-plane is turned by half a turn first
   // ------------------------------------------------------------------------
   logic                          vld_ff  [0:D];
   logic                          last_ff [0:D];
   logic                          org_ff  [0:D];
   logic signed [CW-1:0]          cx_ff   [0:D];
   logic signed [CW-1:0]          cy_ff   [0:D];
   logic        [ACC_WIDTH-1:0]   acc_ff  [0:D];
   logic        [SW-1:0]          rad_ff  [0:D];
   logic        [RW-1:0]          rem_ff  [0:D];
   logic        [DATA_WIDTH-1:0]  root_ff [0:D];

   logic signed [CW-1:0]          xs_in, ys_in;
   logic                          flip_in;

   assign xs_in   = CW'(x2_ff) <<< GUARD_BITS;
   assign ys_in   = CW'(y2_ff) <<< GUARD_BITS;
   assign flip_in = x2_ff[DATA_WIDTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= v2_ff;
      end
      if (adv) begin
         last_ff[0] <= last2_ff;
         org_ff[0]  <= (x2_ff == '0) && (y2_ff == '0);
         cx_ff[0]   <= flip_in ? -xs_in : xs_in;
         cy_ff[0]   <= flip_in ? -ys_in : ys_in;
         acc_ff[0]  <= flip_in ? HALF_TURN : '0;
         rad_ff[0]  <= sqx2_ff + sqy2_ff;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   // ------------------------------------------------------------------------
   // Iteration section: step k does rotation k (while k < STAGES) and root
   // digit k (while k < DATA_WIDTH); past either count that side is held
   // ------------------------------------------------------------------------
   for (genvar k = 0; k < D; k++) begin : g_step
      logic signed [CW-1:0]         cx_in, cy_in;
      logic        [ACC_WIDTH-1:0]  acc_in;
      logic        [RW-1:0]         rem_in;
      logic        [DATA_WIDTH-1:0] root_in;

      if (k < STAGES) begin : g_rot
         logic signed [CW-1:0] dx, dy;
         assign dx = cy_ff[k] >>> k;
         assign dy = cx_ff[k] >>> k;
         // Turn towards the x axis: clockwise while y is non-negative
         always_comb begin
            if (cy_ff[k][CW-1]) begin
               cx_in  = cx_ff[k] - dx;
               cy_in  = cy_ff[k] + dy;
               acc_in = acc_ff[k] - ATAN_TABLE[k];
            end else begin
               cx_in  = cx_ff[k] + dx;
               cy_in  = cy_ff[k] - dy;
               acc_in = acc_ff[k] + ATAN_TABLE[k];
            end
         end
      end else begin : g_rot_hold
         assign cx_in  = cx_ff[k];
         assign cy_in  = cy_ff[k];
         assign acc_in = acc_ff[k];
      end

      if (k < DATA_WIDTH) begin : g_root
         logic [RW-1:0] rem_sh, trial;
         // Bring down the next two radicand bits and try the next root bit
         assign rem_sh = {rem_ff[k][RW-3:0], rad_ff[k][SW-1-2*k -: 2]};
         assign trial  = {1'b0, root_ff[k], 2'b01};
         always_comb begin
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[k][DATA_WIDTH-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[k][DATA_WIDTH-2:0], 1'b0};
            end
         end
      end else begin : g_root_hold
         assign rem_in  = rem_ff[k];
         assign root_in = root_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (adv) begin
            last_ff[k+1] <= last_ff[k];
            org_ff[k+1]  <= org_ff[k];
            cx_ff[k+1]   <= cx_in;
            cy_ff[k+1]   <= cy_in;
            acc_ff[k+1]  <= acc_in;
            rad_ff[k+1]  <= rad_ff[k];
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Output stage: round the angle half up to ANGLE_WIDTH bits (wrapping at a
   // full turn), round the root to nearest, and force the origin to zero angle
   // ------------------------------------------------------------------------
   logic [ANGLE_WIDTH-1:0] ang_rnd;
   logic [DATA_WIDTH-1:0]  mag_in;
   logic [ANGLE_WIDTH-1:0] ang_in;

   if (ANGLE_WIDTH < ACC_WIDTH) begin : g_ang_round
      logic [ACC_WIDTH-1:0] acc_rnd;
      assign acc_rnd = acc_ff[D] + (ACC_WIDTH'(1) << (ACC_WIDTH - 1 - ANGLE_WIDTH));
      assign ang_rnd = acc_rnd[ACC_WIDTH-1 -: ANGLE_WIDTH];
   end else begin : g_ang_full
      assign ang_rnd = acc_ff[D][ANGLE_WIDTH-1:0];
   end

   // The remainder exceeding the root means the true root lies at or above root + 1/2
   assign mag_in = root_ff[D] + DATA_WIDTH'(rem_ff[D] > RW'(root_ff[D]));
   assign ang_in = org_ff[D] ? '0 : ang_rnd;

   logic                   rsp_valid_ff;
   logic [DATA_WIDTH-1:0]  rsp_magnitude_ff;
   logic [ANGLE_WIDTH-1:0] rsp_angle_ff;
   logic                   rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[D];
      end
      if (adv) begin
         rsp_magnitude_ff <= mag_in;
         rsp_angle_ff     <= ang_in;
         rsp_last_ff      <= last_ff[D];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_magnitude_ff;
   assign rsp_angle     = rsp_angle_ff;
   assign rsp_last_out  = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // After the half-turn set-up the rotator always starts in the right half-plane
   a_right_half: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> !cx_ff[0][CW-1])
      else $error("rotator starts with negative x");

   // The final root remainder never exceeds twice the root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[D] |-> (rem_ff[D] <= {root_ff[D], 1'b0}))
      else $error("square root remainder out of range");

   // The origin leaves the pipeline as zero magnitude and zero angle
   a_origin: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[D] && org_ff[D] |=> rsp_valid && rsp_angle == '0 && rsp_magnitude == '0)
      else $error("origin gives a non-zero result");

   // A point at the end of the pipeline reaches the output when it advances
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[D] |=> rsp_valid)
      else $error("result lost at the output stage");

   // A held result must hold the whole pipeline, and so the request side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall ##1 $stable(vld_ff[D]))
      else $error("pipeline moved under a held result");

endmodule

// File: sim/tb_rectangular_to_polar_unit.sv
`timescale 1ns / 100ps

module tb_rectangular_to_polar_unit;
   import rtp_pkg::*;

   localparam int DW = 16;
   localparam int AW = 16;
   localparam int ST = 16;
   // drain allowance: the iteration steps plus the capture, squaring and set-up registers
   localparam int LATENCY = ((ST > DW) ? ST : DW) + 3;
   // cycles without any transfer before the run is abandoned
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PER_PHASE = 300;
   localparam int DIRECTED_N = 20;

   // corners and near-corners of the coordinate range
   localparam int CORNER_VALUES [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

   // origin, axis extremes, corners, unit steps, the point just below a full turn
   localparam int DIR_X [DIRECTED_N] = '{
      0, 32767, -32768, 0, 0, 32767, -32768, -32768, 32767, 1,
      0, -1, 0, 1, -1, -1, 1, 32767, 3, -3
   };
   localparam int DIR_Y [DIRECTED_N] = '{
      0, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768, 0,
      1, 0, -1, 1, -1, 1, -1, -1, 4, -4
   };

   typedef enum int {
      SHAPE_FULL,
      SHAPE_SMALL,
      SHAPE_AXIS,
      SHAPE_CORNER,
      SHAPE_DIAGONAL
   } point_shape_type;

   typedef struct packed {
      logic [DW-1:0] magnitude;
      logic [AW-1:0] angle;
      logic          last_out;
   } polar_result_type;

   // Expected polar results, in the order the points were accepted.
   class polar_scoreboard;
      polar_result_type expected_q [$];
      int unsigned      failures;
      int unsigned      checked;

      function new();
         failures = 0;
         checked  = 0;
      endfunction

      // integer square root, rounded to nearest
      function logic [DW-1:0] rounded_root(longint unsigned sum_sq);
         longint unsigned rem;
         longint unsigned root;
         longint unsigned probe;
         rem   = sum_sq;
         root  = 0;
         probe = 64'd1 << 62;
         while (probe > rem)
            probe = probe >> 2;
         while (probe != 0) begin
            if (rem >= root + probe) begin
               rem  = rem - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe = probe >> 2;
         end
         if (rem > root)
            root++;
         return root[DW-1:0];
      endfunction

      // vectoring rotation towards the x axis, accumulating the turned angle
      function logic [AW-1:0] cordic_angle(longint px, longint py);
         longint              cx;
         longint              cy;
         longint              dx;
         longint              dy;
         logic [ACC_WIDTH-1:0] acc;
         if (px == 0 && py == 0)
            return '0;
         cx  = px <<< GUARD_BITS;
         cy  = py <<< GUARD_BITS;
         acc = '0;
         // left half-plane: rotate by half a turn first
         if (px < 0) begin
            cx  = -cx;
            cy  = -cy;
            acc = HALF_TURN;
         end
         for (int i = 0; i < ST && i < ATAN_DEPTH; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy < 0) begin
               cx  = cx - dx;
               cy  = cy + dy;
               acc = acc - ATAN_TABLE[i];
            end else begin
               cx  = cx + dx;
               cy  = cy - dy;
               acc = acc + ATAN_TABLE[i];
            end
         end
         // round half up; the top of the circle wraps to zero
         acc = acc + (32'd1 << (ACC_WIDTH - 1 - AW));
         return acc[ACC_WIDTH-1 -: AW];
      endfunction

      function void note_point(logic signed [DW-1:0] x, logic signed [DW-1:0] y,
                               logic is_last);
         polar_result_type r;
         longint           px;
         longint           py;
         longint unsigned  ax;
         longint unsigned  ay;
         px = x;
         py = y;
         ax = (px < 0) ? -px : px;
         ay = (py < 0) ? -py : py;
         r.magnitude = rounded_root(ax * ax + ay * ay);
         r.angle     = cordic_angle(px, py);
         r.last_out  = is_last;
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [DW-1:0] magnitude, logic [AW-1:0] angle,
                                 logic last_out);
         polar_result_type want;
         if (expected_q.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, expected none, actual magnitude %0d angle %0d",
                     $time, magnitude, angle);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (magnitude !== want.magnitude) begin
            failures++;
            $display("%0t: magnitude expected %0d actual %0d", $time, want.magnitude,
                     magnitude);
         end
         if (angle !== want.angle) begin
            failures++;
            $display("%0t: angle expected %0d actual %0d", $time, want.angle, angle);
         end
         if (last_out !== want.last_out) begin
            failures++;
            $display("%0t: last_out expected %0b actual %0b", $time, want.last_out,
                     last_out);
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [DW-1:0] req_x_coord;
   logic signed [DW-1:0] req_y_coord;
   logic                 req_last_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic        [DW-1:0] rsp_magnitude;
   logic        [AW-1:0] rsp_angle;
   logic                 rsp_last_out;

   polar_scoreboard polar_sb;

   // per-phase idling rates, in percent of cycles
   int send_idle_pct;
   int recv_stall_pct;

   int unsigned points_in;
   int unsigned results_out;
   int unsigned batch_ends;
   int unsigned quiet_cycles;

   rectangular_to_polar_unit #(
      .DATA_WIDTH (DW),
      .ANGLE_WIDTH(AW),
      .STAGES     (ST)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_x_coord  (req_x_coord),
      .req_y_coord  (req_y_coord),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_magnitude(rsp_magnitude),
      .rsp_angle    (rsp_angle),
      .rsp_last_out (rsp_last_out)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver side: raise stall at random on the falling edge, at the rate of the phase.
   always @(negedge clock) begin
      rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
   end

   // Monitor both channels at the rising edge, before the block's registers update.
   // Note each input transfer, check each result transfer, and keep the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if ($isunknown(req_stall) || $isunknown(rsp_valid)) begin
            polar_sb.failures++;
            $display("%0t: handshake expected known, actual req_stall %b rsp_valid %b",
                     $time, req_stall, rsp_valid);
         end
         if (req_valid && !req_stall) begin
            polar_sb.note_point(req_x_coord, req_y_coord, req_last_in);
            points_in++;
            if (req_last_in)
               batch_ends++;
         end
         if (rsp_valid && !rsp_stall) begin
            polar_sb.check_result(rsp_magnitude, rsp_angle, rsp_last_out);
            results_out++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, polar_sb.pending());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Offer one point, idling first at the phase's rate; call and return on a falling edge.
   // Valid stays high from one point to the next unless an idle cycle falls between.
   task automatic send_point(logic signed [DW-1:0] x, logic signed [DW-1:0] y,
                             logic is_last);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      req_last_in <= is_last;
      // hold the payload until the transfer completes
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   // Draw a point of a random shape: most often full-range, with corners, axes,
   // diagonals and tiny values to reach the awkward parts of the circle.
   task automatic random_point(output logic signed [DW-1:0] x,
                               output logic signed [DW-1:0] y);
      point_shape_type shape;
      int              offset;
      shape = point_shape_type'($urandom_range(SHAPE_DIAGONAL + 2));
      case (shape)
         SHAPE_SMALL: begin
            x = DW'($urandom_range(32) - 16);
            y = DW'($urandom_range(32) - 16);
         end
         SHAPE_AXIS: begin
            if ($urandom_range(1)) begin
               x = DW'($urandom());
               y = DW'($urandom_range(4) - 2);
            end else begin
               x = DW'($urandom_range(4) - 2);
               y = DW'($urandom());
            end
         end
         SHAPE_CORNER: begin
            x = DW'(CORNER_VALUES[$urandom_range(6)]);
            y = DW'(CORNER_VALUES[$urandom_range(6)]);
         end
         SHAPE_DIAGONAL: begin
            x      = DW'($urandom());
            offset = $urandom_range(6) - 3;
            y      = $urandom_range(1) ? DW'(int'(x) + offset) : DW'(-int'(x) + offset);
         end
         default: begin
            x = DW'($urandom());
            y = DW'($urandom());
         end
      endcase
   endtask

   task automatic run_phase(int n, int idle_pct, int stall_pct);
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (n) begin
         random_point(x, y);
         send_point(x, y, $urandom_range(7) == 0);
      end
   endtask

   initial begin
      polar_sb       = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      points_in      = 0;
      results_out    = 0;
      batch_ends     = 0;
      quiet_cycles   = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_x_coord    = '0;
      req_y_coord    = '0;
      req_last_in    = 1'b0;

      // hold reset, then release it on a falling edge
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed points back to back, with a batch mark on every fourth
      for (int i = 0; i < DIRECTED_N; i++)
         send_point(DW'(DIR_X[i]), DW'(DIR_Y[i]), (i % 4) == 3);

      run_phase(RANDOM_PER_PHASE, 0, 0);
      run_phase(RANDOM_PER_PHASE, 57, 0);
      run_phase(RANDOM_PER_PHASE, 0, 57);
      run_phase(RANDOM_PER_PHASE, 20, 20);

      // drop valid, drain the pipeline, then allow for stray results
      req_valid <= 1'b0;
      while (polar_sb.pending() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      $display("Converted %0d points (%0d batch ends) over directed, steady, sender-gap,",
               points_in, batch_ends);
      $display("receiver-stall and mixed phases; %0d results compared, %0d mismatches.",
               results_out, polar_sb.failures);
      if (polar_sb.failures == 0 && polar_sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
